// ===== src/matrix_add_multiply_transpose_macros.svh =====
// assertion macros of the matrix engine rtl
// no dependencies; included by files that carry concurrent checks
`ifndef MATRIX_ADD_MULTIPLY_TRANSPOSE_MACROS_SVH
`define MATRIX_ADD_MULTIPLY_TRANSPOSE_MACROS_SVH

// same-cycle implication, off during reset
`define MAMT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define MAMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mamt_pkg.sv =====
// shared types, constants and helpers of the matrix engine
// no dependencies; used by every module of the block but mamt_ram
package mamt_pkg;

   localparam int MAX_DIM      = 8;
   localparam int DATA_W       = 32;
   localparam int SIZE_W       = 4;
   localparam int OP_W         = 2;
   localparam int FIELD_W      = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 4;
   localparam int IDX_W        = $clog2(MAX_DIM);
   localparam int DIM_W        = $clog2(MAX_DIM + 1);
   localparam int ADDR_W       = $clog2(MAX_DIM * MAX_DIM);
   localparam int CNT_W        = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int FLAT_W       = IDX_W + DIM_W + 1;
   localparam int RSP_TDATA_W  = 40;
   localparam int RSP_PAD_W    = RSP_TDATA_W - DATA_W - 2 * FIELD_W;
   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
   localparam int JQ_DEPTH     = 2;
   localparam int JQ_PTR_W     = $clog2(JQ_DEPTH);
   localparam int JQ_CNT_W     = $clog2(JQ_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_MUL = 2'd1;
   localparam logic [OP_W-1:0] OP_TRN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_SECOND = 3'd4;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_MUL,
      KIND_TRN,
      KIND_ERR
   } kind_type;

   typedef enum logic {
      GEN_IDLE,
      GEN_RUN
   } gen_state_type;

   // one run handed from the loader to the compute side
   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   last_row;
      logic [IDX_W-1:0]   last_col;
      logic [IDX_W-1:0]   last_k;
      logic [DIM_W-1:0]   width_first;
      logic [DIM_W-1:0]   width_second;
   } job_type;

   typedef struct packed {
      logic    full;
      logic    valid;
   } jq_status_type;

   typedef struct packed {
      logic                en_first;
      logic                en_second;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
   } ram_wr_type;

   // travels with each read through the compute pipeline
   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic               first_k;
      logic               last_k;
      logic               fin;
   } tag_type;

   typedef struct packed {
      logic [DATA_W-1:0]    value;
      logic [FIELD_W-1:0]   row;
      logic [FIELD_W-1:0]   col;
      logic                 last;
      logic                 err;
   } rsp_type;

   // zero reads as one, oversize clamps to the maximum
   function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
      logic [DIM_W-1:0] res;
      if (r == '0) begin
         res = DIM_W'(1);
      end else if (int'(r) > MAX_DIM) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = DIM_W'(r);
      end
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] m;
      m = d - DIM_W'(1);
      return m[IDX_W-1:0];
   endfunction

   // row-major address r * w + c
   function automatic logic [ADDR_W-1:0] flat_addr(input logic [IDX_W-1:0] r,
                                                   input logic [DIM_W-1:0] w,
                                                   input logic [IDX_W-1:0] c);
      logic [FLAT_W-1:0] full;
      full = FLAT_W'(r) * FLAT_W'(w) + FLAT_W'(c);
      return full[ADDR_W-1:0];
   endfunction

endpackage

// ===== src/mamt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module mamt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mamt_front.sv =====
// loader: configuration registers, element intake and run classification
// depends on mamt_pkg
module mamt_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mamt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mamt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mamt_pkg::DATA_W-1:0]        req_tdata,
   output mamt_pkg::ram_wr_type               ram_wr,
   input  mamt_pkg::jq_status_type            jq_stat,
   output logic                               job_push,
   output mamt_pkg::job_type                  job,
   input  logic                               back_done
);

   logic [mamt_pkg::OP_W-1:0]     op_ff, op_in;
   logic [mamt_pkg::SIZE_W-1:0]   rows_first_ff, rows_first_in;
   logic [mamt_pkg::SIZE_W-1:0]   cols_first_ff, cols_first_in;
   logic [mamt_pkg::SIZE_W-1:0]   rows_second_ff, rows_second_in;
   logic [mamt_pkg::SIZE_W-1:0]   cols_second_ff, cols_second_in;
   logic [mamt_pkg::CNT_W-1:0]    load_count_ff, load_count_in;
   logic                          loading_second_ff, loading_second_in;
   logic                          busy_ff, busy_in;

   logic [mamt_pkg::DIM_W-1:0]    r1, c1, r2, c2;
   logic [mamt_pkg::CNT_W-1:0]    n1, n2, cnt_next;
   logic                          accept, is_trn, end_first, end_second;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff             <= mamt_pkg::OP_ADD;
         rows_first_ff     <= mamt_pkg::SIZE_W'(1);
         cols_first_ff     <= mamt_pkg::SIZE_W'(1);
         rows_second_ff    <= mamt_pkg::SIZE_W'(1);
         cols_second_ff    <= mamt_pkg::SIZE_W'(1);
         load_count_ff     <= '0;
         loading_second_ff <= 1'b0;
         busy_ff           <= 1'b0;
      end else begin
         op_ff             <= op_in;
         rows_first_ff     <= rows_first_in;
         cols_first_ff     <= cols_first_in;
         rows_second_ff    <= rows_second_in;
         cols_second_ff    <= cols_second_in;
         load_count_ff     <= load_count_in;
         loading_second_ff <= loading_second_in;
         busy_ff           <= busy_in;
      end
   end

   always_comb begin
      r1 = mamt_pkg::eff_size(rows_first_ff);
      c1 = mamt_pkg::eff_size(cols_first_ff);
      r2 = mamt_pkg::eff_size(rows_second_ff);
      c2 = mamt_pkg::eff_size(cols_second_ff);
      n1 = mamt_pkg::CNT_W'(r1) * mamt_pkg::CNT_W'(c1);
      n2 = mamt_pkg::CNT_W'(r2) * mamt_pkg::CNT_W'(c2);
      // the unused selector code acts as transpose
      is_trn = (op_ff != mamt_pkg::OP_ADD) && (op_ff != mamt_pkg::OP_MUL);

      req_tready = !busy_ff && !jq_stat.full;
      accept     = req_tvalid && req_tready;
      cnt_next   = load_count_ff + mamt_pkg::CNT_W'(1);
      end_first  = !loading_second_ff && (cnt_next == n1);
      end_second = loading_second_ff && (cnt_next == n2);

      ram_wr.en_first  = accept && !loading_second_ff;
      ram_wr.en_second = accept && loading_second_ff;
      ram_wr.addr      = load_count_ff[mamt_pkg::ADDR_W-1:0];
      ram_wr.data      = req_tdata;

      job.width_first  = c1;
      job.width_second = c2;
      if (is_trn) begin
         job.kind     = mamt_pkg::KIND_TRN;
         job.last_row = mamt_pkg::last_idx(c1);
         job.last_col = mamt_pkg::last_idx(r1);
         job.last_k   = '0;
      end else if (op_ff == mamt_pkg::OP_ADD) begin
         job.kind     = ((r1 == r2) && (c1 == c2)) ? mamt_pkg::KIND_ADD : mamt_pkg::KIND_ERR;
         job.last_row = (job.kind == mamt_pkg::KIND_ADD) ? mamt_pkg::last_idx(r1) : '0;
         job.last_col = (job.kind == mamt_pkg::KIND_ADD) ? mamt_pkg::last_idx(c1) : '0;
         job.last_k   = '0;
      end else begin
         job.kind     = (c1 == r2) ? mamt_pkg::KIND_MUL : mamt_pkg::KIND_ERR;
         job.last_row = (job.kind == mamt_pkg::KIND_MUL) ? mamt_pkg::last_idx(r1) : '0;
         job.last_col = (job.kind == mamt_pkg::KIND_MUL) ? mamt_pkg::last_idx(c2) : '0;
         job.last_k   = (job.kind == mamt_pkg::KIND_MUL) ? mamt_pkg::last_idx(c1) : '0;
      end

      op_in             = op_ff;
      rows_first_in     = rows_first_ff;
      cols_first_in     = cols_first_ff;
      rows_second_in    = rows_second_ff;
      cols_second_in    = cols_second_ff;
      load_count_in     = load_count_ff;
      loading_second_in = loading_second_ff;
      busy_in           = busy_ff && !back_done;
      job_push          = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            mamt_pkg::CSR_OPERATION: begin
               op_in = csr_wdata[mamt_pkg::OP_W-1:0];
            end
            mamt_pkg::CSR_ROWS_FIRST: begin
               rows_first_in = csr_wdata;
            end
            mamt_pkg::CSR_COLS_FIRST: begin
               cols_first_in = csr_wdata;
            end
            mamt_pkg::CSR_ROWS_SECOND: begin
               rows_second_in = csr_wdata;
            end
            mamt_pkg::CSR_COLS_SECOND: begin
               cols_second_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      priority if (csr_we && (csr_index <= mamt_pkg::CSR_COLS_SECOND)) begin
         // any register write restarts loading
         load_count_in     = '0;
         loading_second_in = 1'b0;
      end else if (accept) begin
         load_count_in = cnt_next;
         if (end_first && is_trn) begin
            load_count_in = '0;
            job_push      = 1'b1;
            busy_in       = 1'b1;
         end else if (end_first) begin
            load_count_in     = '0;
            loading_second_in = 1'b1;
         end else if (end_second) begin
            load_count_in     = '0;
            loading_second_in = 1'b0;
            job_push          = 1'b1;
            busy_in           = 1'b1;
         end
      end else begin
         // no transfer and no register write: loading state holds
      end
   end

endmodule

// ===== src/mamt_jobq.sv =====
// two-entry queue of run descriptors between loader and compute side
// depends on mamt_pkg
module mamt_jobq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mamt_pkg::job_type           push_job,
   input  logic                        pop,
   output mamt_pkg::job_type           head_job,
   output mamt_pkg::jq_status_type     stat
);

   mamt_pkg::job_type                  entries_ff [mamt_pkg::JQ_DEPTH];
   mamt_pkg::job_type                  entry_in;
   logic [mamt_pkg::JQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mamt_pkg::JQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mamt_pkg::JQ_CNT_W-1:0]      count_ff, count_in;
   logic                               do_push, do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_comb begin
      stat.full  = (count_ff == mamt_pkg::JQ_CNT_W'(mamt_pkg::JQ_DEPTH));
      stat.valid = (count_ff != '0);
      head_job   = entries_ff[rd_ptr_ff];
      entry_in   = push_job;
      do_push    = push && !stat.full;
      do_pop     = pop && stat.valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + mamt_pkg::JQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + mamt_pkg::JQ_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + mamt_pkg::JQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - mamt_pkg::JQ_CNT_W'(1);
      end
   end

endmodule

// ===== src/mamt_back.sv =====
// compute side: index sequencer, read / combine / accumulate pipeline, result fifo
// depends on mamt_pkg; reads the two element stores through registered ports
module mamt_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  mamt_pkg::job_type                   job,
   output logic                                job_pop,
   output logic                                done,
   output logic [mamt_pkg::ADDR_W-1:0]         first_rd_addr,
   output logic [mamt_pkg::ADDR_W-1:0]         second_rd_addr,
   input  logic [mamt_pkg::DATA_W-1:0]         first_rd_data,
   input  logic [mamt_pkg::DATA_W-1:0]         second_rd_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mamt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);

   mamt_pkg::gen_state_type          state_ff, state_in;
   mamt_pkg::job_type                job_ff, job_in;
   logic [mamt_pkg::IDX_W-1:0]       a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [mamt_pkg::OUT_CNT_W-1:0]   credit_ff, credit_in;
   mamt_pkg::tag_type                cur_tag;
   logic                             issue;

   logic                             s1_valid_ff, s1_valid_in;
   mamt_pkg::tag_type                s1_tag_ff, s1_tag_in;
   logic                             s2_valid_ff, s2_valid_in;
   mamt_pkg::tag_type                s2_tag_ff, s2_tag_in;
   logic [mamt_pkg::DATA_W-1:0]      term_ff, term_in;
   logic [mamt_pkg::DATA_W-1:0]      acc_ff, acc_in, acc_sum;

   mamt_pkg::rsp_type                fifo_ff [mamt_pkg::OUT_DEPTH];
   mamt_pkg::rsp_type                fifo_in, head;
   logic [mamt_pkg::OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mamt_pkg::OUT_CNT_W-1:0]   count_ff, count_in;
   logic                             push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mamt_pkg::GEN_IDLE;
         credit_ff   <= mamt_pkg::OUT_CNT_W'(mamt_pkg::OUT_DEPTH);
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         credit_ff   <= credit_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      s1_tag_ff <= s1_tag_in;
      s2_tag_ff <= s2_tag_in;
      term_ff   <= term_in;
      acc_ff    <= acc_in;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= fifo_in;
      end
   end

   // sequencer: row, column and inner index of the current read
   always_comb begin
      cur_tag.kind    = job_ff.kind;
      cur_tag.row     = a_ff;
      cur_tag.col     = b_ff;
      cur_tag.first_k = (k_ff == '0);
      cur_tag.last_k  = (k_ff == job_ff.last_k);
      cur_tag.fin     = (a_ff == job_ff.last_row) && (b_ff == job_ff.last_col);

      unique case (job_ff.kind)
         mamt_pkg::KIND_MUL: begin
            first_rd_addr  = mamt_pkg::flat_addr(a_ff, job_ff.width_first, k_ff);
            second_rd_addr = mamt_pkg::flat_addr(k_ff, job_ff.width_second, b_ff);
         end
         mamt_pkg::KIND_TRN: begin
            first_rd_addr  = mamt_pkg::flat_addr(b_ff, job_ff.width_first, a_ff);
            second_rd_addr = '0;
         end
         default: begin
            first_rd_addr  = mamt_pkg::flat_addr(a_ff, job_ff.width_first, b_ff);
            second_rd_addr = first_rd_addr;
         end
      endcase

      // a read that closes a result needs a free fifo slot reserved
      issue = (state_ff == mamt_pkg::GEN_RUN) && (!cur_tag.last_k || (credit_ff != '0));

      state_in = state_ff;
      job_in   = job_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      job_pop  = 1'b0;
      done     = 1'b0;

      unique case (state_ff)
         mamt_pkg::GEN_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               a_in     = '0;
               b_in     = '0;
               k_in     = '0;
               state_in = mamt_pkg::GEN_RUN;
            end
         end
         mamt_pkg::GEN_RUN: begin
            if (issue) begin
               if (!cur_tag.last_k) begin
                  k_in = k_ff + mamt_pkg::IDX_W'(1);
               end else if (b_ff != job_ff.last_col) begin
                  k_in = '0;
                  b_in = b_ff + mamt_pkg::IDX_W'(1);
               end else if (a_ff != job_ff.last_row) begin
                  k_in = '0;
                  b_in = '0;
                  a_in = a_ff + mamt_pkg::IDX_W'(1);
               end else begin
                  done     = 1'b1;
                  state_in = mamt_pkg::GEN_IDLE;
               end
            end
         end
         default: begin
            state_in = mamt_pkg::GEN_IDLE;
         end
      endcase
   end

   // pipeline: read, combine, accumulate
   always_comb begin
      s1_valid_in = issue;
      s1_tag_in   = cur_tag;
      s2_valid_in = s1_valid_ff;
      s2_tag_in   = s1_tag_ff;

      unique case (s1_tag_ff.kind)
         mamt_pkg::KIND_ADD: term_in = first_rd_data + second_rd_data;
         mamt_pkg::KIND_MUL: term_in = first_rd_data * second_rd_data;
         mamt_pkg::KIND_TRN: term_in = first_rd_data;
         default:            term_in = '0;
      endcase

      acc_sum = (s2_tag_ff.first_k ? '0 : acc_ff) + term_ff;
      acc_in  = s2_valid_ff ? acc_sum : acc_ff;
      push    = s2_valid_ff && s2_tag_ff.last_k;

      fifo_in.value = acc_sum;
      fifo_in.row   = mamt_pkg::FIELD_W'(s2_tag_ff.row);
      fifo_in.col   = mamt_pkg::FIELD_W'(s2_tag_ff.col);
      fifo_in.last  = s2_tag_ff.fin;
      fifo_in.err   = (s2_tag_ff.kind == mamt_pkg::KIND_ERR);
   end

   // result fifo and slot credits
   always_comb begin
      head       = fifo_ff[rd_ptr_ff];
      rsp_tvalid = (count_ff != '0);
      pop        = rsp_tvalid && rsp_tready;
      rsp_tdata  = {{mamt_pkg::RSP_PAD_W{1'b0}}, head.col, head.row, head.value};
      rsp_tlast  = head.last;
      rsp_tuser  = head.err;

      wr_ptr_in = push ? wr_ptr_ff + mamt_pkg::OUT_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + mamt_pkg::OUT_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + mamt_pkg::OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mamt_pkg::OUT_CNT_W'(1);
      end

      credit_in = credit_ff;
      if ((issue && cur_tag.last_k) && !pop) begin
         credit_in = credit_ff - mamt_pkg::OUT_CNT_W'(1);
      end else if (pop && !(issue && cur_tag.last_k)) begin
         credit_in = credit_ff + mamt_pkg::OUT_CNT_W'(1);
      end
   end

endmodule

// ===== src/matrix_add_multiply_transpose.sv =====
// top level of the integer matrix add / multiply / transpose engine
// depends on mamt_pkg, mamt_ram, mamt_front, mamt_jobq, mamt_back and the macro header
//
// usage: write operation and sizes on the csr port while the block is idle.
// req carries one signed 32-bit element per transfer: the first matrix
// row-major, then the second (skipped for transpose). The element store takes
// one element per cycle. After the final element the run is queued for the
// compute side and req_tready drops until the compute side has read the stores.
// rsp carries results row-major with row, col, tlast on the final one and
// tuser set on a size-mismatch error (one item, value zero).
// after the final element the run passes the job queue, the sequencer, the store
// read, combine and accumulate steps and the result fifo. The store read port sets
// the rate: one result per cycle for add and transpose while the result fifo has
// room; multiply reads cols_first element pairs for each result.
// a four-entry result fifo absorbs rsp stalls; the sequencer pauses when all its slots are reserved.
// reset clears loading state and sets operation add and all sizes to one.
`include "matrix_add_multiply_transpose_macros.svh"

module matrix_add_multiply_transpose (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mamt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mamt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mamt_pkg::DATA_W-1:0]         req_tdata,   // [31:0] element
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mamt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [31:0] value, [34:32] row, [37:35] col
   output logic                                rsp_tlast,
   output logic                                rsp_tuser    // [0] error
);

   mamt_pkg::ram_wr_type                 ram_wr;
   mamt_pkg::jq_status_type              jq_stat;
   mamt_pkg::job_type                    push_job, head_job;
   logic                                 job_push, job_pop, back_done;
   logic [mamt_pkg::ADDR_W-1:0]          first_rd_addr, second_rd_addr;
   logic [mamt_pkg::DATA_W-1:0]          first_rd_data, second_rd_data;

   mamt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .ram_wr     (ram_wr),
      .jq_stat    (jq_stat),
      .job_push   (job_push),
      .job        (push_job),
      .back_done  (back_done)
   );

   mamt_ram #(
      .WIDTH (mamt_pkg::DATA_W),
      .DEPTH (mamt_pkg::STORE_DEPTH)
   ) u_first_store (
      .clock   (clock),
      .wr_en   (ram_wr.en_first),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (first_rd_addr),
      .rd_data (first_rd_data)
   );

   mamt_ram #(
      .WIDTH (mamt_pkg::DATA_W),
      .DEPTH (mamt_pkg::STORE_DEPTH)
   ) u_second_store (
      .clock   (clock),
      .wr_en   (ram_wr.en_second),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (second_rd_addr),
      .rd_data (second_rd_data)
   );

   mamt_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .stat     (jq_stat)
   );

   mamt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (jq_stat.valid),
      .job            (head_job),
      .job_pop        (job_pop),
      .done           (back_done),
      .first_rd_addr  (first_rd_addr),
      .second_rd_addr (second_rd_addr),
      .first_rd_data  (first_rd_data),
      .second_rd_data (second_rd_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

   `MAMT_ASSERT_IMPLY(a_jobq_room, clock, reset, job_push, !jq_stat.full, "job queue overflow")
   `MAMT_ASSERT_NEXT(a_load_blocked, clock, reset, job_push, !req_tready, "loader open after run end")
   `MAMT_ASSERT_IMPLY(a_done_vs_push, clock, reset, back_done, !job_push, "run done while next queued")

endmodule

// ===== bench/tb_matrix_add_multiply_transpose.sv =====
// self-checking bench for matrix_add_multiply_transpose: streams elements, predicts results
// with its own matrix engine model and compares every rsp transfer field by field
// depends on mamt_pkg and the rtl of the block
module tb_matrix_add_multiply_transpose;
   timeunit 1ns;
   timeprecision 1ps;
   import mamt_pkg::*;

   localparam int CYCLE_LIMIT   = 500_000;
   localparam int RANDOM_ITEMS  = 330;
   localparam int SETTLE_CYCLES = 24;
   localparam int END_CYCLES    = 64;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_COLS_SECOND + 3'd1;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [DATA_W-1:0]        req_tdata;    // [31:0] element
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;    // [31:0] value, [34:32] row, [37:35] col
   logic                     rsp_tlast;
   logic                     rsp_tuser;    // [0] error

   // engine model state
   logic [DATA_W-1:0]   first_mat [STORE_DEPTH];
   logic [DATA_W-1:0]   second_mat [STORE_DEPTH];
   int unsigned         fill_count;
   bit                  on_second;
   logic [OP_W-1:0]     cfg_op;
   logic [SIZE_W-1:0]   cfg_rows_a, cfg_cols_a, cfg_rows_b, cfg_cols_b;
   rsp_type             results_due [$];

   int unsigned   error_count = 0;
   int unsigned   results_checked = 0;
   int unsigned   elements_sent = 0;
   int unsigned   runs_done = 0;
   int unsigned   cycle_count = 0;
   pace_type      pace;

   matrix_add_multiply_transpose dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned usable_dim(input logic [SIZE_W-1:0] r);
      int unsigned d;
      d = 32'(r);
      if (d == 0) begin
         d = 1;
      end else if (d > MAX_DIM) begin
         d = MAX_DIM;
      end
      return d;
   endfunction

   function automatic int unsigned sender_idle_pct();
      int unsigned pct;
      case (pace)
         PACE_SENDER_IDLE: pct = 80;
         PACE_BOTH:        pct = 36;
         default:          pct = 0;
      endcase
      return pct;
   endfunction

   function automatic int unsigned receiver_stall_pct();
      int unsigned pct;
      case (pace)
         PACE_RECEIVER_STALL: pct = 80;
         PACE_BOTH:           pct = 36;
         default:             pct = 0;
      endcase
      return pct;
   endfunction

   function automatic void queue_result(input logic [DATA_W-1:0] v, input int unsigned r,
                                        input int unsigned c, input bit fin, input bit bad);
      rsp_type x;
      x.value = v;
      x.row   = FIELD_W'(r);
      x.col   = FIELD_W'(c);
      x.last  = fin;
      x.err   = bad;
      results_due.push_back(x);
   endfunction

   // loads one element and queues whatever the run produces when it completes
   function automatic void take_element(input logic [DATA_W-1:0] e);
      int unsigned ra, ca, rb, cb, i, j, k;
      logic [DATA_W-1:0] acc;
      ra = usable_dim(cfg_rows_a);
      ca = usable_dim(cfg_cols_a);
      rb = usable_dim(cfg_rows_b);
      cb = usable_dim(cfg_cols_b);
      if (!on_second) begin
         first_mat[ADDR_W'(fill_count)] = e;
         fill_count++;
         if (fill_count == ra * ca) begin
            fill_count = 0;
            if (cfg_op == OP_ADD || cfg_op == OP_MUL) begin
               on_second = 1'b1;
            end else begin
               // transpose, and the spare code acts the same: ca rows by ra columns
               for (i = 0; i < ca; i++)
                  for (j = 0; j < ra; j++)
                     queue_result(first_mat[ADDR_W'(j * ca + i)], i, j,
                                  i == ca - 1 && j == ra - 1, 1'b0);
            end
         end
      end else begin
         second_mat[ADDR_W'(fill_count)] = e;
         fill_count++;
         if (fill_count == rb * cb) begin
            fill_count = 0;
            on_second = 1'b0;
            if (cfg_op == OP_ADD) begin
               if (ra != rb || ca != cb) begin
                  queue_result('0, 0, 0, 1'b1, 1'b1);
               end else begin
                  for (i = 0; i < ra; i++)
                     for (j = 0; j < ca; j++)
                        queue_result(first_mat[ADDR_W'(i * ca + j)] +
                                     second_mat[ADDR_W'(i * ca + j)], i, j,
                                     i == ra - 1 && j == ca - 1, 1'b0);
               end
            end else if (ca != rb) begin
               queue_result('0, 0, 0, 1'b1, 1'b1);
            end else begin
               for (i = 0; i < ra; i++)
                  for (j = 0; j < cb; j++) begin
                     acc = '0;
                     for (k = 0; k < ca; k++)
                        acc = acc + first_mat[ADDR_W'(i * ca + k)] *
                                    second_mat[ADDR_W'(k * cb + j)];
                     queue_result(acc, i, j, i == ra - 1 && j == cb - 1, 1'b0);
                  end
            end
         end
      end
   endfunction

   function automatic void note_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] d);
      bit known;
      known = 1'b1;
      case (idx)
         CSR_OPERATION:   cfg_op = d[OP_W-1:0];
         CSR_ROWS_FIRST:  cfg_rows_a = d;
         CSR_COLS_FIRST:  cfg_cols_a = d;
         CSR_ROWS_SECOND: cfg_rows_b = d;
         CSR_COLS_SECOND: cfg_cols_b = d;
         default:         known = 1'b0;
      endcase
      // any real register write throws away a partly loaded run
      if (known) begin
         fill_count = 0;
         on_second = 1'b0;
      end
   endfunction

   function automatic void compare_field(input string field, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         error_count++;
      end
   endfunction

   task automatic check_result();
      rsp_type got, want;
      got.value = rsp_tdata[DATA_W-1:0];
      got.row   = rsp_tdata[DATA_W +: FIELD_W];
      got.col   = rsp_tdata[DATA_W + FIELD_W +: FIELD_W];
      got.last  = rsp_tlast;
      got.err   = rsp_tuser;
      results_checked++;
      if (results_due.size() == 0) begin
         $display("%0t: result with nothing due, expected none actual value %h row %0d col %0d",
                  $time, got.value, got.row, got.col);
         error_count++;
      end else begin
         want = results_due.pop_front();
         compare_field("value", want.value, got.value);
         compare_field("row", DATA_W'(want.row), DATA_W'(got.row));
         compare_field("col", DATA_W'(want.col), DATA_W'(got.col));
         compare_field("last", DATA_W'(want.last), DATA_W'(got.last));
         compare_field("error", DATA_W'(want.err), DATA_W'(got.err));
      end
   endtask

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         rsp_tready <= $urandom_range(0, 99) >= receiver_stall_pct();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results still due", $time, results_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      note_csr_write(idx, d);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // drops req, waits for every due result, then lets the engine settle
   task automatic hold_until_drained(input int unsigned settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic program_engine(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] ra,
                                 input logic [SIZE_W-1:0] ca, input logic [SIZE_W-1:0] rb,
                                 input logic [SIZE_W-1:0] cb);
      hold_until_drained(SETTLE_CYCLES);
      if ($urandom_range(0, 9) == 0)
         write_reg(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 2)), CSR_DATA_W'($urandom));
      // upper data bits are ignored for the operation register
      write_reg(CSR_OPERATION, {OP_W'($urandom_range(0, 3)), op});
      write_reg(CSR_ROWS_FIRST, ra);
      write_reg(CSR_COLS_FIRST, ca);
      write_reg(CSR_ROWS_SECOND, rb);
      write_reg(CSR_COLS_SECOND, cb);
   endtask

   task automatic send_element(input logic [DATA_W-1:0] e);
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      take_element(e);
      elements_sent++;
   endtask

   function automatic logic [DATA_W-1:0] random_element();
      logic [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = {1'b1, {(DATA_W - 1){1'b0}}};
         1:       v = {1'b0, {(DATA_W - 1){1'b1}}};
         2:       v = '1;
         3:       v = DATA_W'($urandom_range(0, 3));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_dim();
      int unsigned x;
      logic [SIZE_W-1:0] d;
      x = $urandom_range(0, 99);
      if (x < 6) begin
         d = '0;
      end else if (x < 11) begin
         d = SIZE_W'($urandom_range(MAX_DIM, (1 << SIZE_W) - 1));
      end else begin
         d = SIZE_W'($urandom_range(1, 3));
      end
      return d;
   endfunction

   task automatic test_reset_defaults();
      // 1x1 add straight out of reset, sum wraps to zero
      send_element(32'h7FFF_FFFF);
      send_element(32'h8000_0001);
   endtask

   task automatic test_transpose();
      program_engine(OP_TRN, 4'd2, 4'd3, 4'd1, 4'd1);
      send_element(32'h0000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'h0000_0001);
      send_element(32'h8000_0000);
      send_element(32'h7FFF_FFFF);
      send_element(32'h1234_5678);
   endtask

   task automatic test_spare_operation();
      // spare code transposes; zero rows reads as one
      program_engine(OP_SPARE, 4'd0, 4'd2, 4'd6, 4'd6);
      send_element(32'hDEAD_BEEF);
      send_element(32'h0000_0007);
   endtask

   task automatic test_multiply_wrap();
      pace = PACE_BOTH;
      program_engine(OP_MUL, 4'd2, 4'd2, 4'd2, 4'd1);
      send_element(32'h7FFF_FFFF);
      send_element(32'h8000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'h0000_0002);
      send_element(32'h7FFF_FFFF);
      send_element(32'hFFFF_FFFF);
      pace = PACE_FULL;
   endtask

   task automatic test_size_mismatch();
      program_engine(OP_ADD, 4'd1, 4'd1, 4'd1, 4'd2);
      repeat (3) send_element(random_element());
      program_engine(OP_MUL, 4'd1, 4'd1, 4'd2, 4'd1);
      repeat (3) send_element(random_element());
   endtask

   task automatic test_abort_partial();
      program_engine(OP_ADD, 4'd2, 4'd1, 4'd2, 4'd1);
      send_element(32'h5555_AAAA);
      // rewriting the sizes restarts loading from the first element
      program_engine(OP_ADD, 4'd1, 4'd1, 4'd1, 4'd1);
      send_element(32'h0000_0003);
      send_element(32'hFFFF_FFFE);
   endtask

   task automatic test_random_runs();
      int unsigned run, start, run_len;
      logic [OP_W-1:0] op;
      logic [SIZE_W-1:0] sa, sb, sc, sd;
      bit fresh, cut;
      run = 0;
      fresh = 1'b1;
      start = elements_sent;
      while (elements_sent - start < RANDOM_ITEMS) begin
         pace = pace_type'((run / 3) % 4);
         if (run == 0) begin
            // oversize rows clamp: largest transpose
            program_engine(OP_TRN, 4'd15, 4'd8, 4'd1, 4'd1);
         end else if (run == 1) begin
            program_engine(OP_MUL, 4'd8, 4'd1, 4'd1, 4'd8);
         end else if (run != 4 && (fresh || $urandom_range(0, 3) != 0)) begin
            op = ($urandom_range(0, 11) == 0) ? OP_SPARE : OP_W'($urandom_range(0, 2));
            sa = pick_dim();
            sb = pick_dim();
            sc = pick_dim();
            sd = pick_dim();
            // most runs get sizes that fit the operation
            if ($urandom_range(0, 6) != 0) begin
               if (op == OP_ADD) begin
                  sc = sa;
                  sd = sb;
               end else if (op == OP_MUL) begin
                  sc = sb;
               end
            end
            program_engine(op, sa, sb, sc, sd);
         end else if (run == 4 || $urandom_range(0, 2) == 0) begin
            hold_until_drained(0);
         end
         run_len = usable_dim(cfg_rows_a) * usable_dim(cfg_cols_a);
         if (cfg_op == OP_ADD || cfg_op == OP_MUL)
            run_len += usable_dim(cfg_rows_b) * usable_dim(cfg_cols_b);
         cut = run_len > 1 && $urandom_range(0, 15) == 0;
         if (cut)
            run_len = $urandom_range(1, run_len - 1);
         repeat (run_len) send_element(random_element());
         fresh = cut;
         run++;
      end
      runs_done = run;
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      pace       = PACE_FULL;
      fill_count = 0;
      on_second  = 1'b0;
      cfg_op     = OP_ADD;
      cfg_rows_a = SIZE_W'(1);
      cfg_cols_a = SIZE_W'(1);
      cfg_rows_b = SIZE_W'(1);
      cfg_cols_b = SIZE_W'(1);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_transpose();
      test_spare_operation();
      test_multiply_wrap();
      test_size_mismatch();
      test_abort_partial();
      test_random_runs();

      hold_until_drained(END_CYCLES);
      $display("sent %0d elements: directed cases plus %0d random runs of add, multiply, transpose",
               elements_sent, runs_done);
      $display("checked %0d result transfers across all pacing modes, %0d mismatches",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
